FILE: rtl/cbss_pkg.sv
// Shared types, constants and helper functions for the caseless substring search.
// No dependencies; used by the channel interfaces and the top level.
package cbss_pkg;

    // payload widths fixed by the channel definitions
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned PLEN_W     = 5;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DELTA   = 8'h20;

    // fold ascii upper case to lower case
    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

    // pick pattern byte i out of the two pattern words
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [CFG_DATA_W-1:0] low_word,
        input logic [CFG_DATA_W-1:0] high_word,
        input logic [3:0]            idx
    );
        logic [CFG_DATA_W-1:0] w;
        w = idx[3] ? high_word : low_word;
        return w[idx[2:0]*BYTE_W +: BYTE_W];
    endfunction

endpackage

FILE: rtl/cbss_if.sv
// Valid/ready channel interfaces for text beats and search result beats.
// Depends on cbss_pkg for payload widths.

interface cbss_text_if;
    logic                        valid;
    logic                        ready;
    logic [cbss_pkg::BYTE_W-1:0] text_byte;
    logic                        window_end;

    modport source (output valid, output text_byte, output window_end, input ready);
    modport sink   (input valid, input text_byte, input window_end, output ready);
endinterface

interface cbss_result_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [cbss_pkg::OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

FILE: rtl/caseless_bounded_substring_search.sv
// Top level of the caseless bounded substring search: history, compare and result.
// Depends on cbss_pkg and the channel interfaces in cbss_if.sv.
//
//   channel   dir  beat contents                 accepted when
//   text      in   text_byte, window_end         text.valid && text.ready
//   result    out  found, match_offset           result.valid && result.ready
//   cfg       in   cfg_index, cfg_data           cfg_write_en
//
// Each text beat is registered in the input stage, then compared against the pattern at all
// alignments at once; the answer lands in the result register.
// One beat per cycle is sustained while result beats are taken.
// The compare stage advances only while the result register is empty or being taken,
// so a held result stalls text after one more beat has been taken in.
// Reset clears the pattern registers and all window state.
module caseless_bounded_substring_search #(
    parameter int unsigned MAX_PATTERN = 16,
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cbss_text_if.sink                           text,
    cbss_result_if.source                       result,
    input  logic                                cfg_write_en,
    input  logic [cbss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned POS_W = OFFSET_BITS + 1;
    localparam logic [POS_W-1:0] OFFSET_MAX = {1'b0, {OFFSET_BITS{1'b1}}};
    localparam logic [POS_W-1:0] POS_CAP    = OFFSET_MAX + POS_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_PATTERN);

    // configuration registers
    logic [cbss_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [cbss_pkg::CFG_DATA_W-1:0] pattern_high_reg;
    logic [cbss_pkg::PLEN_W-1:0]     pattern_len_reg;

    // input stage
    logic                          stage_valid_reg;
    logic [cbss_pkg::BYTE_W-1:0]   stage_byte_reg;
    logic                          stage_end_reg;

    // window state
    logic [cbss_pkg::BYTE_W-1:0]   recent_reg  [MAX_PATTERN];
    logic [cbss_pkg::BYTE_W-1:0]   recent_next [MAX_PATTERN];
    logic [LEN_W-1:0]              run_reg, run_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          done_reg, done_next;
    logic                          ended_reg, ended_next;

    // result register
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [cbss_pkg::OFFSET_W-1:0] out_offset_reg;

    logic                          advance;
    logic                          take_in;
    logic [LEN_W-1:0]              cap_len;
    logic [LEN_W-1:0]              eff_len;
    logic                          zero_seen;
    logic [cbss_pkg::BYTE_W-1:0]   aligned [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]        lane_ok;
    logic                          hit;
    logic [POS_W-1:0]              start_pos;
    logic                          res_valid;
    logic                          res_found;
    logic [cbss_pkg::OFFSET_W-1:0] res_offset;

    assign advance      = !out_valid_reg || result.ready;
    assign take_in      = text.valid && text.ready;
    assign text.ready   = !stage_valid_reg || advance;
    assign result.valid        = out_valid_reg;
    assign result.found        = out_found_reg;
    assign result.match_offset = out_offset_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                cbss_pkg::REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                cbss_pkg::REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                cbss_pkg::REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[cbss_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective pattern length: capped, and cut at the first zero byte
    always_comb
    begin
        cap_len = (pattern_len_reg > cbss_pkg::PLEN_W'(MAX_PATTERN)) ?
                  LEN_MAX : LEN_W'(pattern_len_reg);
        eff_len   = '0;
        zero_seen = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (!zero_seen && LEN_W'(i) < cap_len)
            begin
                if (cbss_pkg::pattern_byte(pattern_low_reg, pattern_high_reg, 4'(i)) == '0)
                begin
                    zero_seen = 1'b1;
                end
                else
                begin
                    eff_len = LEN_W'(i + 1);
                end
            end
        end
    end

    // pattern lined up against the history, newest byte at lane 0
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            aligned[j] = cbss_pkg::fold(cbss_pkg::pattern_byte(
                pattern_low_reg, pattern_high_reg, 4'(int'(eff_len) - 1 - j)));
        end
    end

    // window update and result for the staged beat
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            recent_next[j] = recent_reg[j];
        end
        run_next   = run_reg;
        pos_next   = pos_reg;
        done_next  = done_reg;
        ended_next = ended_reg;
        res_valid  = 1'b0;
        res_found  = 1'b0;
        res_offset = '0;
        hit        = 1'b0;
        lane_ok    = '0;
        start_pos  = pos_reg - POS_W'(eff_len - LEN_W'(1));

        if (stage_valid_reg && advance)
        begin
            if (done_reg)
            begin
                // already answered, wait for the window end
            end
            else if (ended_reg)
            begin
                if (stage_end_reg)
                begin
                    res_valid = 1'b1;
                end
            end
            else if (eff_len == '0)
            begin
                res_valid = 1'b1;
                res_found = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                // shift the folded byte into the history
                recent_next[0] = cbss_pkg::fold(stage_byte_reg);
                for (int j = 1; j < MAX_PATTERN; j++)
                begin
                    recent_next[j] = recent_reg[j-1];
                end
                if (pos_reg < POS_CAP)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end

                if (stage_byte_reg == '0)
                begin
                    ended_next = 1'b1;
                    run_next   = '0;
                end
                else
                begin
                    if (run_reg < LEN_MAX)
                    begin
                        run_next = run_reg + LEN_W'(1);
                    end
                    // compare every lane in use
                    for (int j = 0; j < MAX_PATTERN; j++)
                    begin
                        lane_ok[j] = (LEN_W'(j) >= eff_len) || (recent_next[j] == aligned[j]);
                    end
                    hit = (run_next >= eff_len) && (&lane_ok);
                    if (hit)
                    begin
                        res_valid  = 1'b1;
                        res_found  = 1'b1;
                        res_offset = cbss_pkg::OFFSET_W'(
                            (start_pos > OFFSET_MAX) ? OFFSET_MAX : start_pos);
                        done_next  = 1'b1;
                    end
                end

                if (stage_end_reg && !hit)
                begin
                    res_valid = 1'b1;
                end
            end

            // window end returns all window state to reset
            if (stage_end_reg)
            begin
                for (int j = 0; j < MAX_PATTERN; j++)
                begin
                    recent_next[j] = '0;
                end
                run_next   = '0;
                pos_next   = '0;
                done_next  = 1'b0;
                ended_next = 1'b0;
            end
        end
    end

    // input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_byte_reg <= text.text_byte;
            stage_end_reg  <= text.window_end;
        end
    end

    // window state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                recent_reg[j] <= '0;
            end
            run_reg   <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
            ended_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                recent_reg[j] <= recent_next[j];
            end
            run_reg   <= run_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
            ended_reg <= ended_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_found_reg  <= res_found;
            out_offset_reg <= res_offset;
        end
    end

    // a failed search never carries an offset
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.found || result.match_offset == '0))
        else $error("not-found result with nonzero offset");

    // a window is never both answered and cut by a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && ended_reg))
        else $error("window both answered and ended");

    // the run of nonzero bytes stays within the pattern size
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= LEN_MAX)
        else $error("valid run beyond pattern size");

    // a processed window end leaves clean window state
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && advance && stage_end_reg)
        |=> (pos_reg == '0 && run_reg == '0 && !done_reg && !ended_reg))
        else $error("window state not cleared at window end");

endmodule

FILE: tb/cbss_search_check.sv
`timescale 1ns / 100ps
// Scoreboard for the caseless substring search: tracks pattern writes, predicts
// one answer per window from the text beats and compares each result beat.
// Depends on cbss_pkg and the channel interfaces in cbss_if.sv.
module cbss_search_check (
    input  logic                            clk,
    input  logic                            rst_n,
    cbss_text_if                            text,
    cbss_result_if                          result,
    input  logic                            cfg_write_en,
    input  logic [cbss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbss_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);

    localparam int unsigned PAT_MAX      = 16;
    localparam int unsigned OFFSET_LIMIT = (1 << cbss_pkg::OFFSET_W) - 1;
    localparam int unsigned POS_LIMIT    = OFFSET_LIMIT + PAT_MAX;

    typedef struct packed {
        logic                          found;
        logic [cbss_pkg::OFFSET_W-1:0] offset;
    } answer_t;

    // answers still owed by the block, oldest first
    answer_t expected_answers [$];

    // shadow pattern registers
    logic [cbss_pkg::CFG_DATA_W-1:0] pat_lo;
    logic [cbss_pkg::CFG_DATA_W-1:0] pat_hi;
    logic [cbss_pkg::PLEN_W-1:0]     pat_len;

    // window state, history newest first
    logic [cbss_pkg::BYTE_W-1:0] history [PAT_MAX];
    int unsigned                 run_len;
    int unsigned                 next_pos;
    bit                          answered;
    bit                          text_ended;

    function automatic logic [cbss_pkg::BYTE_W-1:0] to_lower(
        input logic [cbss_pkg::BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [cbss_pkg::BYTE_W-1:0] pat_at(input int unsigned i);
        return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
    endfunction

    // length in use: capped, and cut at the first zero byte
    function automatic int unsigned active_len();
        int unsigned lim;
        int unsigned i;
        lim = (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
        for (i = 0; i < lim; i++)
        begin
            if (pat_at(i) == '0)
            begin
                return i;
            end
        end
        return lim;
    endfunction

    function automatic void clear_window();
        int unsigned i;
        for (i = 0; i < PAT_MAX; i++)
        begin
            history[i] = '0;
        end
        run_len    = 0;
        next_pos   = 0;
        answered   = 1'b0;
        text_ended = 1'b0;
    endfunction

    function automatic void post_answer(input logic f, input int unsigned off);
        answer_t a;
        a.found  = f;
        a.offset = off[cbss_pkg::OFFSET_W-1:0];
        expected_answers.push_back(a);
    endfunction

    // advance the window by one text beat, queueing any answer it yields
    function automatic void scan_byte(input logic [cbss_pkg::BYTE_W-1:0] c,
                                      input logic last);
        int unsigned len;
        int unsigned pos;
        int unsigned start;
        int unsigned i;
        bit          hit;
        bit          gave;
        len  = active_len();
        pos  = next_pos;
        gave = 1'b0;

        // window already answered: swallow until its end
        if (answered)
        begin
            if (last)
            begin
                clear_window();
            end
            return;
        end

        // string ended: only the window end speaks
        if (text_ended)
        begin
            if (last)
            begin
                post_answer(1'b0, 0);
                clear_window();
            end
            return;
        end

        // empty pattern hits on the first beat
        if (len == 0)
        begin
            post_answer(1'b1, 0);
            answered = 1'b1;
            if (last)
            begin
                clear_window();
            end
            return;
        end

        for (i = PAT_MAX - 1; i > 0; i--)
        begin
            history[i] = history[i-1];
        end
        history[0] = to_lower(c);
        if (next_pos < POS_LIMIT)
        begin
            next_pos++;
        end

        if (c == '0)
        begin
            text_ended = 1'b1;
            run_len    = 0;
        end
        else
        begin
            if (run_len < PAT_MAX)
            begin
                run_len++;
            end
            hit = (run_len >= len);
            for (i = 0; i < len; i++)
            begin
                if (history[len-1-i] != to_lower(pat_at(i)))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                start = pos - (len - 1);
                if (start > OFFSET_LIMIT)
                begin
                    start = OFFSET_LIMIT;
                end
                post_answer(1'b1, start);
                answered = 1'b1;
                gave     = 1'b1;
            end
        end

        if (last)
        begin
            if (!gave)
            begin
                post_answer(1'b0, 0);
            end
            clear_window();
        end
    endfunction

    task report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            pat_lo     = '0;
            pat_hi     = '0;
            pat_len    = '0;
            mismatches = 0;
            clear_window();
            expected_answers.delete();
        end
        else
        begin
            // result beat against the oldest answer
            if (result.valid && result.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat found=%0b offset=%0d",
                                              result.found, result.match_offset));
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (result.found !== want.found)
                    begin
                        report_mismatch($sformatf("found is %0b, want %0b",
                                                  result.found, want.found));
                    end
                    if (result.match_offset !== want.offset)
                    begin
                        report_mismatch($sformatf("match_offset is %0d, want %0d",
                                                  result.match_offset, want.offset));
                    end
                end
            end

            // pattern register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    cbss_pkg::REG_PATTERN_LOW:  pat_lo  = cfg_data;
                    cbss_pkg::REG_PATTERN_HIGH: pat_hi  = cfg_data;
                    cbss_pkg::REG_PATTERN_LEN:  pat_len = cfg_data[cbss_pkg::PLEN_W-1:0];
                    default:                    ;
                endcase
            end

            // text beat
            if (text.valid && text.ready)
            begin
                scan_byte(text.text_byte, text.window_end);
            end
        end
        outstanding = expected_answers.size();
    end

endmodule

FILE: tb/tb_caseless_bounded_substring_search.sv
`timescale 1ns / 100ps
// Top of the caseless substring search testbench: clock, reset, pattern writes,
// text windows under several idle mixes, and the final verdict.
// Depends on cbss_pkg, cbss_if.sv, the block and cbss_search_check.
module tb_caseless_bounded_substring_search;

    localparam logic [cbss_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned PAT_MAX       = 16;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 120;

    logic                            clk   = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write_en;
    logic [cbss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cbss_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              mismatches;
    int                              outstanding;
    int                              idle_pct;
    int                              stall_pct;
    int unsigned                     items_sent;

    // stimulus copy of the loaded pattern, for embedding it in text
    logic [cbss_pkg::BYTE_W-1:0] pat_bytes [PAT_MAX];
    int unsigned                 use_len;
    logic [cbss_pkg::BYTE_W-1:0] window_bytes [$];
    string                       alpha = "abcABC";

    cbss_text_if   text_ch ();
    cbss_result_if result_ch ();

    always #5 clk = ~clk;

    caseless_bounded_substring_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text         (text_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cbss_search_check search_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .text         (text_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // receiver stalls
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    initial
    begin
        #5ms;
        $display("caseless_bounded_substring_search verification failed");
        $finish;
    end

    task automatic set_idle(input int unsigned mode);
        case (mode)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 60;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 60;
            end
            default:
            begin
                idle_pct  = 13;
                stall_pct = 13;
            end
        endcase
    endtask

    // one text beat, entered and left at a falling edge
    task automatic send_beat(input logic [cbss_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= b;
        text_ch.window_end <= last;
        @(posedge clk);
        while (!text_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            window_bytes.push_back(s[i]);
        end
    endtask

    task automatic send_window();
        int unsigned i;
        for (i = 0; i < window_bytes.size(); i++)
        begin
            send_beat(window_bytes[i], i == window_bytes.size() - 1);
            items_sent++;
        end
        window_bytes.delete();
    endtask

    // hold the text side until every answer is in
    task automatic drain_results();
        text_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [cbss_pkg::BYTE_W-1:0] flip_case(
        input logic [cbss_pkg::BYTE_W-1:0] b);
        logic letter;
        letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        return (letter && $urandom_range(1)) ? (b ^ 8'h20) : b;
    endfunction

    // write the pattern registers while the block is quiet
    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [cbss_pkg::PLEN_W-1:0] len_val);
        int unsigned k;
        int unsigned lim;
        logic [63:0] upper;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        upper = {$urandom, $urandom};
        cfg_write_en <= 1'b1;
        cfg_index    <= cbss_pkg::REG_PATTERN_LOW;
        cfg_data     <= lo;
        @(negedge clk);
        cfg_index <= cbss_pkg::REG_PATTERN_HIGH;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_index <= cbss_pkg::REG_PATTERN_LEN;
        cfg_data  <= {upper[63:cbss_pkg::PLEN_W], len_val};
        @(negedge clk);
        // spare index must leave the pattern alone
        cfg_index <= REG_SPARE;
        cfg_data  <= ~upper;
        @(negedge clk);
        cfg_write_en <= 1'b0;

        for (k = 0; k < PAT_MAX; k++)
        begin
            pat_bytes[k] = (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
        end
        lim     = (len_val > PAT_MAX) ? PAT_MAX : len_val;
        use_len = lim;
        for (k = lim; k > 0; k--)
        begin
            if (pat_bytes[k-1] == '0)
            begin
                use_len = k - 1;
            end
        end
    endtask

    // random window, often carrying the pattern, sometimes a damaged copy
    task automatic random_window();
        int unsigned n;
        int unsigned at;
        int unsigned r;
        int unsigned k;
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                window_bytes.push_back(alpha[$urandom_range(5)]);
            end
            else if (r < 73)
            begin
                window_bytes.push_back(8'h00);
            end
            else
            begin
                window_bytes.push_back(cbss_pkg::BYTE_W'($urandom_range(255)));
            end
        end
        if (use_len > 0 && use_len <= n && $urandom_range(99) < 60)
        begin
            at = $urandom_range(0, n - use_len);
            for (k = 0; k < use_len; k++)
            begin
                window_bytes[at+k] = flip_case(pat_bytes[k]);
            end
            if ($urandom_range(4) == 0)
            begin
                window_bytes[at + $urandom_range(use_len - 1)] ^= 8'h01;
            end
        end
        send_window();
    endtask

    initial
    begin
        logic [63:0]                 lo;
        logic [63:0]                 hi;
        logic [cbss_pkg::PLEN_W-1:0] lv;
        logic [cbss_pkg::BYTE_W-1:0] b;
        int unsigned                 k;
        int unsigned                 phase;
        int unsigned                 fill;
        int unsigned                 windows;

        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.window_end = 1'b0;
        result_ch.ready    = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = cbss_pkg::REG_PATTERN_LOW;
        cfg_data           = '0;
        idle_pct           = 0;
        stall_pct          = 0;
        items_sent         = 0;
        use_len            = 0;
        for (k = 0; k < PAT_MAX; k++)
        begin
            pat_bytes[k] = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // empty pattern from reset: hit at offset 0, even on a zero byte
        set_idle(0);
        add_text("Q");
        send_window();
        window_bytes.push_back(8'h00);
        send_window();
        add_text("abc");
        send_window();

        // short pattern, mixed case on both sides
        load_pattern(64'h0000_0000_0043_6241, 64'h0, 5'd3);
        add_text("xaBcy");
        send_window();
        // zero byte ends the string before the copy
        add_text("ab");
        window_bytes.push_back(8'h00);
        add_text("abc");
        send_window();

        // zero inside the pattern shortens it
        load_pattern(64'h0000_0000_6400_6261, 64'h0, 5'd4);
        add_text("zAB");
        send_window();

        // full sixteen bytes, length register above the cap
        for (k = 0; k < PAT_MAX; k++)
        begin
            b = alpha[$urandom_range(5)];
            if (k < 8)
            begin
                lo[k*8 +: 8] = b;
            end
            else
            begin
                hi[(k-8)*8 +: 8] = b;
            end
        end
        load_pattern(lo, hi, 5'd31);
        for (k = 0; k < PAT_MAX; k++)
        begin
            window_bytes.push_back(flip_case(pat_bytes[k]));
        end
        send_window();

        // random phases, a fresh pattern each
        for (phase = 0; phase < PHASES; phase++)
        begin
            set_idle(phase % 4);
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            for (k = 0; k < PAT_MAX; k++)
            begin
                if ($urandom_range(9) != 0)
                begin
                    b = alpha[$urandom_range(5)];
                    if (k < 8)
                    begin
                        lo[k*8 +: 8] = b;
                    end
                    else
                    begin
                        hi[(k-8)*8 +: 8] = b;
                    end
                end
            end
            case ($urandom_range(9))
                0:       lv = 5'd0;
                1:       lv = 5'd1;
                2:       lv = 5'd16;
                3:       lv = cbss_pkg::PLEN_W'($urandom_range(17, 31));
                default: lv = cbss_pkg::PLEN_W'($urandom_range(2, 6));
            endcase
            load_pattern(lo, hi, lv);
            fill    = items_sent + PHASE_ITEMS;
            windows = 0;
            while (items_sent < fill)
            begin
                random_window();
                windows++;
                // let the result side run dry now and then
                if (windows % 6 == 5)
                begin
                    drain_results();
                end
            end
        end

        // wind down and give the verdict
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("caseless_bounded_substring_search verification clean");
        end
        else
        begin
            $display("caseless_bounded_substring_search verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/cbss_pkg.sv
rtl/cbss_if.sv
rtl/caseless_bounded_substring_search.sv
tb/cbss_search_check.sv
tb/tb_caseless_bounded_substring_search.sv
